FILE: rtl/core/smph_pkg.sv
// shared types, constants and constant tables of the signal meter peak hold block
`timescale 1ns / 1ps

package smph_pkg;

  typedef enum logic {
    KIND_TICK   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CFG_ALT_SCALE   = 2'd0,
    CFG_HOLD_TIME   = 2'd1,
    CFG_DECAY_ALPHA = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] HOLD_RESET  = 16'd1000;
  localparam logic [15:0] ALPHA_RESET = 16'd1966;

  typedef struct packed {
    logic        alt;
    logic [15:0] hold_ms;
    logic [15:0] alpha;
  } cfg_t;

  // queue depths between the parts
  localparam int unsigned MID_DEPTH = 16;
  localparam int unsigned OUT_DEPTH = 8;

  // whole-dB level search
  localparam int unsigned DB_STEPS  = 8;
  localparam int unsigned DB_W      = 8;
  localparam int unsigned DB_ENTRY  = 2 ** DB_STEPS;
  localparam int unsigned DB_TOP    = 192;
  localparam int unsigned DB_POWER  = 20;
  localparam int unsigned MAG_MAX_W = 32;
  localparam int unsigned THR_W     = MAG_MAX_W + 1;
  localparam int unsigned POW_W     = 672;

  typedef logic [DB_ENTRY-1:0][THR_W-1:0] thr_tab_t;

  typedef struct packed {
    kind_e           kind;
    logic [DB_W-1:0] level;
  } qitem_t;

  typedef struct packed {
    logic [7:0] level_db;
    logic [7:0] peak_db;
    logic       over_s9;
    logic [3:0] s_units;
    logic [7:0] plus_tenths;
    logic [7:0] level_bar;
    logic [7:0] peak_bar;
  } res_t;

  localparam logic [7:0]  OFFSET_NORM   = 8'd90;
  localparam logic [7:0]  OFFSET_ALT    = 8'd46;
  localparam logic [7:0]  THR_NORM      = 8'd41;
  localparam logic [7:0]  THR_ALT       = 8'd36;
  localparam logic [7:0]  LEVEL_MAX     = 8'd146;
  localparam logic [16:0] Q16_ONE       = 17'h10000;

  localparam logic [3:0]  SU_MUL        = 4'd9;
  localparam int unsigned S_UNIT_MAX    = 9;
  localparam logic [5:0]  SU_DEN_NORM   = 6'd40;
  localparam logic [5:0]  SU_DEN_ALT    = 6'd35;

  localparam logic [7:0]  PT_BASE_NORM  = 8'd40;
  localparam logic [7:0]  PT_BASE_ALT   = 8'd35;
  localparam logic [5:0]  PT_MUL_NORM   = 6'd20;
  localparam logic [5:0]  PT_MUL_ALT    = 6'd60;
  localparam logic [5:0]  PT_DEN_NORM   = 6'd13;
  localparam logic [5:0]  PT_DEN_ALT    = 6'd37;
  // floor(2^16 / den) for the tenths quotient
  localparam logic [12:0] PT_RECIP_NORM = 13'd5041;
  localparam logic [12:0] PT_RECIP_ALT  = 13'd1771;
  localparam logic [7:0]  PT_SAT        = 8'd255;

  localparam int unsigned BAR_MUL_NORM  = 263;
  localparam int unsigned BAR_DIV_NORM  = 100;
  localparam int unsigned BAR_MUL_ALT   = 3;

  typedef logic [255:0][7:0] bar_tab_t;

  // smallest magnitude m with m^20 >= 10^k, so that floor(20*log10(m)) >= k
  function automatic thr_tab_t build_db_thr();
    thr_tab_t         tab;
    logic [POW_W-1:0] ten;
    logic [POW_W-1:0] pw;
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] hi;
    logic [THR_W-1:0] mid;
    ten = POW_W'(1);
    for (int k = 0; k < DB_ENTRY; k++) begin
      if (k > DB_TOP) begin
        tab[k] = '1;
      end else begin
        lo = THR_W'(1);
        hi = THR_W'(1) << MAG_MAX_W;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          pw  = POW_W'(1);
          for (int i = 0; i < DB_POWER; i++) begin
            pw = pw * POW_W'(mid);
          end
          if (pw >= ten) begin
            hi = mid;
          end else begin
            lo = mid + THR_W'(1);
          end
        end
        tab[k] = lo;
        ten    = ten * POW_W'(10);
      end
    end
    return tab;
  endfunction

  localparam thr_tab_t DB_THR = build_db_thr();

  // bar position for every whole level, saturated and cut to the port width
  function automatic bar_tab_t build_bar_tab(input logic alt, input int unsigned bar_max);
    bar_tab_t    tab;
    int unsigned b;
    for (int unsigned w = 0; w < 256; w++) begin
      b = alt ? w * BAR_MUL_ALT : (w * BAR_MUL_NORM) / BAR_DIV_NORM;
      if (b > bar_max) begin
        b = bar_max;
      end
      tab[w] = 8'(b);
    end
    return tab;
  endfunction

endpackage

FILE: rtl/core/smph_fifo.sv
// small first-in first-out queue of registers used between the parts
`timescale 1ns / 1ps

module smph_fifo #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W:0]   wr_q, wr_d;
  logic [PTR_W:0]   rd_q, rd_d;
  logic             full;
  logic             wr_en;
  logic             rd_en;

  assign empty_o = (wr_q == rd_q);
  assign full    = (wr_q[PTR_W] != rd_q[PTR_W]) && (wr_q[PTR_W-1:0] == rd_q[PTR_W-1:0]);
  assign wr_en   = push_i && !full;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem[rd_q[PTR_W-1:0]];

  always_comb begin
    wr_d = wr_en ? wr_q + 1'b1 : wr_q;
    rd_d = rd_en ? rd_q + 1'b1 : rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_q[PTR_W-1:0]] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  // credit counting upstream must keep the queue from overflowing
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full)
    else $error("item pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("item popped from an empty queue");
`endif

endmodule

FILE: rtl/core/smph_front.sv
// front part: input acceptance, credit count and pipelined whole-dB level search
`timescale 1ns / 1ps

module smph_front
  import smph_pkg::*;
#(
  parameter int unsigned MAG_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_push_i,
  output logic                in_full_o,
  input  logic                kind_i,
  input  logic [MAG_BITS-1:0] magnitude_i,
  input  cfg_t                cfg_i,
  input  logic                q_pop_i,
  output logic                q_push_o,
  output qitem_t              q_item_o
);

  localparam int unsigned CNT_W = $clog2(MID_DEPTH + 1);

  // items accepted and not yet taken from the middle queue
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                accept;

  logic                v_s    [DB_STEPS+1];
  kind_e               kind_s [DB_STEPS+1];
  logic [MAG_BITS-1:0] mag_s  [DB_STEPS+1];
  logic [DB_W-1:0]     r_s    [DB_STEPS+1];

  logic [DB_W-1:0]     offset;
  logic [DB_W-1:0]     level;

  assign in_full_o = (cnt_q == CNT_W'(MID_DEPTH));
  assign accept    = in_push_i && !in_full_o;

  always_comb begin
    cnt_d = cnt_q + CNT_W'(accept) - CNT_W'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign v_s[0]    = accept;
  assign kind_s[0] = kind_e'(kind_i);
  assign mag_s[0]  = magnitude_i;
  assign r_s[0]    = '0;

  // one result bit per rank, from the top bit down
  for (genvar i = 0; i < DB_STEPS; i++) begin : g_step
    localparam logic [DB_W-1:0] STEP_BIT = DB_W'(1) << (DB_STEPS - 1 - i);

    logic [DB_W-1:0]     cand;
    logic                hit;
    logic                v_q;
    kind_e               kind_q;
    logic [MAG_BITS-1:0] mag_q;
    logic [DB_W-1:0]     r_q;

    assign cand = r_s[i] | STEP_BIT;
    assign hit  = THR_W'(mag_s[i]) >= DB_THR[cand];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= v_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      kind_q <= kind_s[i];
      mag_q  <= mag_s[i];
      r_q    <= hit ? cand : r_s[i];
    end

    assign v_s[i+1]    = v_q;
    assign kind_s[i+1] = kind_q;
    assign mag_s[i+1]  = mag_q;
    assign r_s[i+1]    = r_q;
  end

  always_comb begin
    offset = cfg_i.alt ? OFFSET_ALT : OFFSET_NORM;
    level  = (r_s[DB_STEPS] > offset) ? r_s[DB_STEPS] - offset : '0;
  end

  assign q_push_o       = v_s[DB_STEPS];
  assign q_item_o.kind  = kind_s[DB_STEPS];
  assign q_item_o.level = level;

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MID_DEPTH))
    else $error("front credit count out of range");
  a_credit_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != '0)
    else $error("queue item taken with no credit outstanding");
`endif

endmodule

FILE: rtl/core/smph_back.sv
// back part: peak hold and decay loop, readout pipeline and result credit count
`timescale 1ns / 1ps

module smph_back
  import smph_pkg::*;
#(
  parameter int unsigned BAR_MAX = 208
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   q_empty_i,
  input  qitem_t q_item_i,
  output logic   q_pop_o,
  input  logic   out_pop_i,
  output logic   res_push_o,
  output res_t   res_o
);

  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);
  localparam bar_tab_t BAR_NORM = build_bar_tab(1'b0, BAR_MAX);
  localparam bar_tab_t BAR_ALT  = build_bar_tab(1'b1, BAR_MAX);

  // samples taken from the queue whose results have not left the output queue
  logic [OCW-1:0] ocnt_q, ocnt_d;
  logic           room;
  logic           take_tick;
  logic           take_sample;

  logic [23:0]    peak_q, peak_d;
  logic [15:0]    timer_q, timer_d;
  logic [23:0]    lq;
  logic           rise;
  logic           decay_en;
  logic [16:0]    one_minus;
  logic [40:0]    keep_prod;
  logic [23:0]    gain_prod;
  logic [25:0]    decay_sum;

  logic           r1_v_q;
  logic [7:0]     r1_level_q;
  logic [23:0]    r1_peak_q;
  logic [7:0]     thr;
  logic           over1;
  logic [5:0]     su_den;
  logic [27:0]    su_prod;
  logic [11:0]    su_y;
  logic [3:0]     su1;
  logic [7:0]     pt_base;
  logic [5:0]     pt_mul;
  logic [23:0]    pt_diff;
  logic [29:0]    pt_prod;
  logic [7:0]     lbar1;
  logic [7:0]     pbar1;

  logic           r2_v_q;
  logic [7:0]     r2_level_q;
  logic [7:0]     r2_peak_q;
  logic           r2_over_q;
  logic [3:0]     r2_su_q;
  logic [13:0]    r2_z_q;
  logic [7:0]     r2_lbar_q;
  logic [7:0]     r2_pbar_q;
  logic [5:0]     pt_den;
  logic [12:0]    pt_recip;
  logic           zsat2;
  logic [26:0]    q0_prod;

  logic           r3_v_q;
  logic [7:0]     r3_level_q;
  logic [7:0]     r3_peak_q;
  logic           r3_over_q;
  logic [3:0]     r3_su_q;
  logic [13:0]    r3_z_q;
  logic [10:0]    r3_q0_q;
  logic           r3_sat_q;
  logic [7:0]     r3_lbar_q;
  logic [7:0]     r3_pbar_q;
  logic [16:0]    qd;
  logic [16:0]    rem;
  logic [10:0]    q_fix;
  logic [7:0]     tenths;

  // ticks need no result slot, samples wait for one
  assign room        = (ocnt_q < OCW'(OUT_DEPTH));
  assign q_pop_o     = !q_empty_i && ((q_item_i.kind == KIND_TICK) || room);
  assign take_tick   = q_pop_o && (q_item_i.kind == KIND_TICK);
  assign take_sample = q_pop_o && (q_item_i.kind == KIND_SAMPLE);

  always_comb begin
    ocnt_d = ocnt_q + OCW'(take_sample) - OCW'(out_pop_i);
  end

  // peak update, one queue item a cycle while the queue holds items and, for a sample, a result slot is free
  always_comb begin
    lq        = {q_item_i.level, 16'h0000};
    rise      = lq > peak_q;
    decay_en  = timer_q > cfg_i.hold_ms;
    one_minus = Q16_ONE - {1'b0, cfg_i.alpha};
    keep_prod = 41'(peak_q) * 41'(one_minus);
    gain_prod = 24'(q_item_i.level) * 24'(cfg_i.alpha);
    decay_sum = 26'(keep_prod[40:16]) + 26'(gain_prod);
  end

  always_comb begin
    peak_d  = peak_q;
    timer_d = timer_q;
    if (take_tick && (timer_q != '1)) begin
      timer_d = timer_q + 16'd1;
    end
    if (take_sample) begin
      if (rise) begin
        peak_d  = lq;
        timer_d = '0;
      end else if (decay_en) begin
        peak_d = decay_sum[23:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q  <= '0;
      peak_q  <= '0;
      timer_q <= '0;
      r1_v_q  <= 1'b0;
      r2_v_q  <= 1'b0;
      r3_v_q  <= 1'b0;
    end else begin
      ocnt_q  <= ocnt_d;
      peak_q  <= peak_d;
      timer_q <= timer_d;
      r1_v_q  <= take_sample;
      r2_v_q  <= r1_v_q;
      r3_v_q  <= r2_v_q;
    end
  end

  // readout rank 1: threshold, s units, scaled excess over s9, bars
  always_comb begin
    thr     = cfg_i.alt ? THR_ALT : THR_NORM;
    over1   = r1_peak_q >= {thr, 16'h0000};
    su_den  = cfg_i.alt ? SU_DEN_ALT : SU_DEN_NORM;
    su_prod = 28'(r1_peak_q) * 28'(SU_MUL);
    su_y    = su_prod[27:16];
    su1     = '0;
    for (int j = 1; j <= S_UNIT_MAX; j++) begin
      if (su_y >= 12'(int'(su_den) * j)) begin
        su1 = 4'(j);
      end
    end
    if (over1) begin
      su1 = '0;
    end
    pt_base = cfg_i.alt ? PT_BASE_ALT : PT_BASE_NORM;
    pt_mul  = cfg_i.alt ? PT_MUL_ALT : PT_MUL_NORM;
    pt_diff = r1_peak_q - {pt_base, 16'h0000};
    pt_prod = 30'(pt_diff) * 30'(pt_mul);
    lbar1   = cfg_i.alt ? BAR_ALT[r1_level_q] : BAR_NORM[r1_level_q];
    pbar1   = cfg_i.alt ? BAR_ALT[r1_peak_q[23:16]] : BAR_NORM[r1_peak_q[23:16]];
  end

  // readout rank 2: reciprocal estimate of the tenths quotient
  always_comb begin
    pt_den   = cfg_i.alt ? PT_DEN_ALT : PT_DEN_NORM;
    pt_recip = cfg_i.alt ? PT_RECIP_ALT : PT_RECIP_NORM;
    zsat2    = r2_z_q >= {pt_den, 8'h00};
    q0_prod  = 27'(r2_z_q) * 27'(pt_recip);
  end

  // readout rank 3: estimate is low by at most one
  always_comb begin
    qd     = 17'(r3_q0_q) * 17'(pt_den);
    rem    = 17'(r3_z_q) - qd;
    q_fix  = (rem >= 17'(pt_den)) ? r3_q0_q + 11'd1 : r3_q0_q;
    tenths = '0;
    if (r3_over_q) begin
      tenths = r3_sat_q ? PT_SAT : q_fix[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    r1_level_q <= q_item_i.level;
    r1_peak_q  <= peak_d;

    r2_level_q <= r1_level_q;
    r2_peak_q  <= r1_peak_q[23:16];
    r2_over_q  <= over1;
    r2_su_q    <= su1;
    r2_z_q     <= pt_prod[29:16];
    r2_lbar_q  <= lbar1;
    r2_pbar_q  <= pbar1;

    r3_level_q <= r2_level_q;
    r3_peak_q  <= r2_peak_q;
    r3_over_q  <= r2_over_q;
    r3_su_q    <= r2_su_q;
    r3_z_q     <= r2_z_q;
    r3_q0_q    <= q0_prod[26:16];
    r3_sat_q   <= zsat2;
    r3_lbar_q  <= r2_lbar_q;
    r3_pbar_q  <= r2_pbar_q;
  end

  assign res_push_o        = r3_v_q;
  assign res_o.level_db    = r3_level_q;
  assign res_o.peak_db     = r3_peak_q;
  assign res_o.over_s9     = r3_over_q;
  assign res_o.s_units     = r3_su_q;
  assign res_o.plus_tenths = tenths;
  assign res_o.level_bar   = r3_lbar_q;
  assign res_o.peak_bar    = r3_pbar_q;

`ifndef NO_ASSERTIONS
  a_out_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= OCW'(OUT_DEPTH))
    else $error("result credit count above output queue depth");
  // decay is a weighted mean, so the peak never passes the largest level
  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_sample |=> peak_q <= {LEVEL_MAX, 16'h0000})
    else $error("peak above the largest possible level");
`endif

endmodule

FILE: rtl/core/signal_meter_peak_hold_top.sv
// signal meter with peak hold and decay: top level
//
// input queue side: push with kind_i and magnitude_i, taken while full is low.
// kind 0 is a one millisecond tick, kind 1 a magnitude sample. every sample
// gives one result, a tick gives none but moves the hold timer in order.
// result queue side: the oldest result sits on the result ports while empty is
// low and is taken with pop.
// configuration: cfg_valid_i with cfg_index_i and cfg_data_i, always ready;
// index 0 alternate scale, 1 hold time in ticks, 2 decay weight in Q16.
// one item a cycle sustained while full is low. on its way a sample passes
// eight ranks of level search (one dB bit each), the middle queue, the
// peak register (the only loop) and three readout ranks.
// reset clears peak and hold timer, empties both queues and loads the default
// configuration; items are taken from the first cycle after reset.
// when the receiver stalls, the output queue holds 8 results and full rises once
// 16 items wait in the front ranks and the middle queue.
`timescale 1ns / 1ps

module signal_meter_peak_hold_top
  import smph_pkg::*;
#(
  parameter int unsigned MAG_BITS = 32,
  parameter int unsigned BAR_MAX  = 208
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  kind_i,
  input  logic [MAG_BITS-1:0]   magnitude_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            level_db_o,
  output logic [7:0]            peak_db_o,
  output logic                  over_s9_o,
  output logic [3:0]            s_units_o,
  output logic [7:0]            plus_tenths_o,
  output logic [7:0]            level_bar_o,
  output logic [7:0]            peak_bar_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t   cfg_q, cfg_d;
  logic   cfg_we;

  logic   mid_push;
  qitem_t mid_wr;
  qitem_t mid_rd;
  logic   mid_empty;
  logic   mid_pop;

  logic   res_push;
  res_t   res_wr;
  res_t   res_rd;
  logic   out_pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ALT_SCALE:   cfg_d.alt     = cfg_data_i[0];
        CFG_HOLD_TIME:   cfg_d.hold_ms = cfg_data_i;
        CFG_DECAY_ALPHA: cfg_d.alpha   = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alt     <= 1'b0;
      cfg_q.hold_ms <= HOLD_RESET;
      cfg_q.alpha   <= ALPHA_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  smph_front #(
    .MAG_BITS(MAG_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_push_i  (push),
    .in_full_o  (full),
    .kind_i     (kind_i),
    .magnitude_i(magnitude_i),
    .cfg_i      (cfg_q),
    .q_pop_i    (mid_pop),
    .q_push_o   (mid_push),
    .q_item_o   (mid_wr)
  );

  smph_fifo #(
    .WIDTH($bits(qitem_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .data_i (mid_wr),
    .pop_i  (mid_pop),
    .data_o (mid_rd),
    .empty_o(mid_empty)
  );

  smph_back #(
    .BAR_MAX(BAR_MAX)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (mid_empty),
    .q_item_i  (mid_rd),
    .q_pop_o   (mid_pop),
    .out_pop_i (out_pop),
    .res_push_o(res_push),
    .res_o     (res_wr)
  );

  smph_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_wr),
    .pop_i  (out_pop),
    .data_o (res_rd),
    .empty_o(empty)
  );

  assign out_pop       = pop && !empty;
  assign level_db_o    = res_rd.level_db;
  assign peak_db_o     = res_rd.peak_db;
  assign over_s9_o     = res_rd.over_s9;
  assign s_units_o     = res_rd.s_units;
  assign plus_tenths_o = res_rd.plus_tenths;
  assign level_bar_o   = res_rd.level_bar;
  assign peak_bar_o    = res_rd.peak_bar;

endmodule

FILE: dv/signal_meter_peak_hold_checker.sv
// checker for the signal meter: predicts every reading and compares it with the result side
`timescale 1ns / 1ps

module signal_meter_peak_hold_checker
  import smph_pkg::*;
#(
  parameter int unsigned MAG_BITS = 32,
  parameter int unsigned BAR_MAX  = 208
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  logic                  full,
  input  logic                  kind_i,
  input  logic [MAG_BITS-1:0]   magnitude_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [7:0]            level_db_i,
  input  logic [7:0]            peak_db_i,
  input  logic                  over_s9_i,
  input  logic [3:0]            s_units_i,
  input  logic [7:0]            plus_tenths_i,
  input  logic [7:0]            level_bar_i,
  input  logic [7:0]            peak_bar_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o
);

  localparam int unsigned POW_BITS  = 672;
  localparam int unsigned PRINT_CAP = 40;

  logic        alt_scale;
  logic [15:0] hold_ms;
  logic [15:0] alpha_q16;
  logic [23:0] peak_q16;
  logic [15:0] ticks_since_rise;
  res_t        readings_due[$];

  // largest k with 10^k <= m^20, done on wide integers so it is exact
  function automatic logic [7:0] whole_db(input logic [31:0] m);
    logic [POW_BITS-1:0] pw;
    logic [POW_BITS-1:0] ten;
    logic [7:0]          k;
    pw  = POW_BITS'(1);
    ten = POW_BITS'(10);
    k   = '0;
    for (int i = 0; i < DB_POWER; i++) begin
      pw = pw * POW_BITS'(m);
    end
    if (m != '0) begin
      while (k != 8'd255 && ten <= pw) begin
        k++;
        ten = ten * POW_BITS'(10);
      end
    end
    return k;
  endfunction

  function automatic logic [7:0] bar_pos(input logic [7:0] whole);
    int unsigned b;
    b = alt_scale ? int'(whole) * BAR_MUL_ALT : (int'(whole) * BAR_MUL_NORM) / BAR_DIV_NORM;
    if (b > BAR_MAX) begin
      b = BAR_MAX;
    end
    return 8'(b);
  endfunction

  // peak moves first, the readout then uses the new peak
  function automatic res_t predict_reading(input logic [31:0] m);
    res_t        r;
    logic [7:0]  raw;
    logic [7:0]  offs;
    logic [7:0]  lvl;
    logic [7:0]  thr;
    logic [7:0]  base;
    logic [23:0] lq;
    logic [63:0] acc;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    raw  = whole_db(m);
    offs = alt_scale ? OFFSET_ALT : OFFSET_NORM;
    lvl  = (raw > offs) ? raw - offs : 8'd0;
    lq   = {lvl, 16'h0000};
    if (lq > peak_q16) begin
      peak_q16         = lq;
      ticks_since_rise = '0;
    end else if (ticks_since_rise > hold_ms) begin
      acc = 64'(peak_q16) * (64'(Q16_ONE) - 64'(alpha_q16)) + 64'(lq) * 64'(alpha_q16);
      peak_q16 = acc[39:16];
    end
    thr  = alt_scale ? THR_ALT : THR_NORM;
    base = alt_scale ? PT_BASE_ALT : PT_BASE_NORM;
    r = '0;
    r.level_db = lvl;
    r.peak_db  = peak_q16[23:16];
    r.over_s9  = (peak_q16 >= {thr, 16'h0000});
    if (!r.over_s9) begin
      num = 64'(peak_q16) * 64'(SU_MUL);
      den = 64'(alt_scale ? SU_DEN_ALT : SU_DEN_NORM) << 16;
      r.s_units = 4'(num / den);
    end else begin
      num = (64'(peak_q16) - (64'(base) << 16)) * 64'(alt_scale ? PT_MUL_ALT : PT_MUL_NORM);
      den = 64'(alt_scale ? PT_DEN_ALT : PT_DEN_NORM) << 16;
      quo = num / den;
      r.plus_tenths = (quo > 64'(PT_SAT)) ? PT_SAT : quo[7:0];
    end
    r.level_bar = bar_pos(lvl);
    r.peak_bar  = bar_pos(peak_q16[23:16]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count_o++;
    if (fail_count_o <= PRINT_CAP) begin
      $display("%0t: reading %0d %s: got %0d, want %0d", $time, checked_o, what, got, want);
    end
  endtask

  task automatic check_reading();
    res_t want;
    if (readings_due.size() == 0) begin
      report_mismatch("result with no sample waiting", 0, 0);
      return;
    end
    want = readings_due.pop_front();
    if (level_db_i != want.level_db) report_mismatch("level_db", level_db_i, want.level_db);
    if (peak_db_i != want.peak_db) report_mismatch("peak_db", peak_db_i, want.peak_db);
    if (over_s9_i != want.over_s9) report_mismatch("over_s9", over_s9_i, want.over_s9);
    if (s_units_i != want.s_units) report_mismatch("s_units", s_units_i, want.s_units);
    if (plus_tenths_i != want.plus_tenths) begin
      report_mismatch("plus_tenths", plus_tenths_i, want.plus_tenths);
    end
    if (level_bar_i != want.level_bar) begin
      report_mismatch("level_bar", level_bar_i, want.level_bar);
    end
    if (peak_bar_i != want.peak_bar) report_mismatch("peak_bar", peak_bar_i, want.peak_bar);
    checked_o++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      alt_scale        = 1'b0;
      hold_ms          = HOLD_RESET;
      alpha_q16        = ALPHA_RESET;
      peak_q16         = '0;
      ticks_since_rise = '0;
      readings_due.delete();
      fail_count_o     = 0;
      checked_o        = 0;
      pending_o        = 0;
    end else begin
      if (pop && !empty) begin
        check_reading();
      end
      if (push && !full) begin
        if (kind_i == KIND_SAMPLE) begin
          readings_due.push_back(predict_reading(32'(magnitude_i)));
        end else if (ticks_since_rise != 16'hFFFF) begin
          ticks_since_rise++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ALT_SCALE:   alt_scale = cfg_data_i[0];
          CFG_HOLD_TIME:   hold_ms   = cfg_data_i;
          CFG_DECAY_ALPHA: alpha_q16 = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = readings_due.size();
    end
  end

endmodule

FILE: dv/tb_signal_meter_peak_hold_top.sv
// testbench top: drives samples, ticks and register writes into the signal meter
`timescale 1ns / 1ps

module tb_signal_meter_peak_hold_top;
  import smph_pkg::*;

  localparam int unsigned MAG_BITS        = 32;
  localparam int unsigned BAR_MAX         = 208;
  localparam int unsigned RAND_PHASES     = 7;
  localparam int unsigned ITEMS_PER_PHASE = 55;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned RX_HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned MAX_BURST       = 24;
  localparam int unsigned LONG_TICKS      = 32;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX = CFG_IDX_W'(3);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  kind = KIND_TICK;
  logic [MAG_BITS-1:0]   magnitude = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            level_db;
  logic [7:0]            peak_db;
  logic                  over_s9;
  logic [3:0]            s_units;
  logic [7:0]            plus_tenths;
  logic [7:0]            level_bar;
  logic [7:0]            peak_bar;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned stall_cycles = 0;
  int unsigned samples_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned settings_run = 0;
  logic [15:0] hold_set = HOLD_RESET;
  logic        tx_idle_en = 1'b1;
  logic        rx_hold_req = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  signal_meter_peak_hold_top #(
    .MAG_BITS(MAG_BITS),
    .BAR_MAX (BAR_MAX)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind),
    .magnitude_i  (magnitude),
    .empty        (empty),
    .pop          (pop),
    .level_db_o   (level_db),
    .peak_db_o    (peak_db),
    .over_s9_o    (over_s9),
    .s_units_o    (s_units),
    .plus_tenths_o(plus_tenths),
    .level_bar_o  (level_bar),
    .peak_bar_o   (peak_bar),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  signal_meter_peak_hold_checker #(
    .MAG_BITS(MAG_BITS),
    .BAR_MAX (BAR_MAX)
  ) meter_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind),
    .magnitude_i  (magnitude),
    .empty        (empty),
    .pop          (pop),
    .level_db_i   (level_db),
    .peak_db_i    (peak_db),
    .over_s9_i    (over_s9),
    .s_units_i    (s_units),
    .plus_tenths_i(plus_tenths),
    .level_bar_i  (level_bar),
    .peak_bar_i   (peak_bar),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // ends the run if nothing moves on any channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no item moved for %0d cycles, %0d readings outstanding",
                 stall_cycles, pending);
        $display("[signal_meter_peak_hold_top] ERROR");
        $finish;
      end
    end
  end

  // push stays high from one item to the next unless a gap is drawn
  task automatic send_item(input kind_e k, input logic [MAG_BITS-1:0] m);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push      <= 1'b1;
    kind      <= k;
    magnitude <= m;
    do @(posedge clk_i); while (full);
    if (k == KIND_SAMPLE) begin
      samples_sent++;
    end else begin
      ticks_sent++;
    end
  endtask

  task automatic send_ticks(input int unsigned n);
    logic saved;
    saved      = tx_idle_en;
    tx_idle_en = 1'b0;
    repeat (n) send_item(KIND_TICK, MAG_BITS'($urandom()));
    tx_idle_en = saved;
  endtask

  // ticks give no reading, so allow the pipe to drain them too
  task automatic wait_idle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic alt, input logic [15:0] hold, input logic [15:0] alpha);
    wait_idle();
    write_reg(CFG_ALT_SCALE, {15'($urandom()), alt});
    write_reg(CFG_HOLD_TIME, hold);
    write_reg(CFG_DECAY_ALPHA, alpha);
    hold_set = hold;
    settings_run++;
  endtask

  // magnitude close to a given whole-dB value, a count either side
  function automatic logic [MAG_BITS-1:0] mag_near_db(input int unsigned db);
    real    r;
    longint v;
    longint top;
    r   = $pow(10.0, db / 20.0);
    top = (longint'(1) << MAG_BITS) - 1;
    v   = longint'(r) + longint'($urandom_range(0, 2)) - 1;
    if (v < 0) begin
      v = 0;
    end
    if (v > top) begin
      v = top;
    end
    return MAG_BITS'(v);
  endfunction

  function automatic logic [MAG_BITS-1:0] pick_magnitude();
    case ($urandom_range(0, 9))
      0:       pick_magnitude = MAG_BITS'($urandom());
      1:       pick_magnitude = MAG_BITS'($urandom() >> $urandom_range(0, 31));
      2:       pick_magnitude = $urandom_range(0, 1) ? '0 : '1;
      3:       pick_magnitude = mag_near_db($urandom_range(0, 192));
      default: pick_magnitude = mag_near_db($urandom_range(30, 192));
    endcase
  endfunction

  task automatic run_random_phase(input int unsigned n);
    int unsigned pick;
    int unsigned burst;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        tx_idle_en = !tx_idle_en;
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // enough ticks to run past a short hold time
        burst = int'(hold_set) + 1 + $urandom_range(0, 3);
        send_ticks((burst > MAX_BURST) ? MAX_BURST : burst);
      end else if (pick < 8) begin
        send_item(KIND_TICK, MAG_BITS'($urandom()));
      end else begin
        send_item(KIND_SAMPLE, pick_magnitude());
      end
    end
    tx_idle_en = 1'b1;
  endtask

  initial begin : result_drain
    int unsigned gap;
    logic        rx_idle_en;
    rx_idle_en = 1'b1;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        rx_idle_en = !rx_idle_en;
      end
      gap = rx_idle_en ? $urandom_range(0, 6) : 0;
      // long hold-off so the sender fills the block and full rises
      if (rx_hold_req) begin
        gap         = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin : stimulus
    int unsigned sweep_alt[6]  = '{192, 150, 82, 81, 60, 0};
    int unsigned sweep_norm[6] = '{192, 131, 130, 100, 90, 0};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero, smallest, around the offset, full scale twice, a drop
    send_item(KIND_SAMPLE, '0);
    send_item(KIND_SAMPLE, MAG_BITS'(1));
    send_item(KIND_SAMPLE, MAG_BITS'(31622));
    send_item(KIND_SAMPLE, MAG_BITS'(35482));
    send_item(KIND_SAMPLE, '1);
    send_item(KIND_SAMPLE, '1);
    send_item(KIND_SAMPLE, MAG_BITS'(1000));
    send_ticks(int'(HOLD_RESET) + 1);
    send_item(KIND_SAMPLE, MAG_BITS'(35482));

    // near-instant decay walks the peak down across the s9 threshold
    set_config(1'b1, 16'd0, 16'hFFFF);
    foreach (sweep_alt[i]) begin
      send_item(KIND_TICK, MAG_BITS'($urandom()));
      send_item(KIND_SAMPLE, mag_near_db(sweep_alt[i]));
    end
    set_config(1'b0, 16'd0, 16'hFFFF);
    foreach (sweep_norm[i]) begin
      send_item(KIND_TICK, MAG_BITS'($urandom()));
      send_item(KIND_SAMPLE, mag_near_db(sweep_norm[i]));
    end

    // largest hold times keep the peak, a spare register index is ignored
    set_config(1'b0, 16'hFFFF, 16'd0);
    write_reg(SPARE_IDX, 16'($urandom()));
    send_item(KIND_SAMPLE, '1);
    send_ticks(LONG_TICKS);
    send_item(KIND_SAMPLE, MAG_BITS'(1));
    wait_idle();
    write_reg(CFG_HOLD_TIME, 16'hFFFE);
    hold_set = 16'hFFFE;
    send_item(KIND_SAMPLE, MAG_BITS'(1));
    wait_idle();
    write_reg(CFG_DECAY_ALPHA, 16'hFFFF);
    send_item(KIND_SAMPLE, MAG_BITS'(1));

    rx_hold_req = 1'b1;
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: set_config(1'b0, 16'd5, ALPHA_RESET);
        1: set_config(1'b1, HOLD_RESET, 16'hFFFF);
        2: set_config(1'b0, 16'd0, 16'd0);
        3: set_config(1'b1, 16'hFFFF, 16'($urandom()));
        default: begin
          set_config(1'($urandom_range(0, 1)),
                     $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom()),
                     $urandom_range(0, 2) == 0 ? 16'hFFFF : 16'($urandom()));
        end
      endcase
      run_random_phase(ITEMS_PER_PHASE);
    end

    wait_idle();
    $display("sent %0d samples and %0d ticks under %0d register settings",
             samples_sent, ticks_sent, settings_run + 1);
    $display("%0d readings compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[signal_meter_peak_hold_top] OK");
    end else begin
      $display("[signal_meter_peak_hold_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/smph_pkg.sv
rtl/core/smph_fifo.sv
rtl/core/smph_front.sv
rtl/core/smph_back.sv
rtl/core/signal_meter_peak_hold_top.sv
dv/signal_meter_peak_hold_checker.sv
dv/tb_signal_meter_peak_hold_top.sv
